>>> src/c3f_pkg.sv
// Shared types and constants for the 3x3 RGB convolution filter.
// Used by every module of the filter; depends on nothing else.
package c3f_pkg;

  localparam int PIX_W      = 24;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 11;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int KROW_W     = 48;
  localparam int DIV_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int MAX_HEIGHT = 4096;
  localparam int CH_MAX     = 255;
  localparam int TAPS       = 3;
  localparam int ACC_W      = 29;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_TOP    = 3'd0,
    REG_KERNEL_MIDDLE = 3'd1,
    REG_KERNEL_BOTTOM = 3'd2,
    REG_DIVIDE_BY     = 3'd3,
    REG_FRAME_WIDTH   = 3'd4,
    REG_FRAME_HEIGHT  = 3'd5
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // Neighborhood entry k is row k/3 (top first), column k%3 (left first).
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pixel_t           px;
    pixel_t [8:0]     nb;
    logic             interior;
    logic             border;
  } job_t;

  typedef struct packed {
    logic [KROW_W-1:0] top;
    logic [KROW_W-1:0] mid;
    logic [KROW_W-1:0] bot;
    logic [DIV_W-1:0]  divisor;
  } kernel_cfg_t;

endpackage

>>> src/c3f_front.sv
// Front end of the filter: pixel intake, raster counters, line stores and window.
// Classifies each pixel and pushes a job into the queue for each interior or border pixel. Depends on c3f_pkg.
module c3f_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [c3f_pkg::FW_W-1:0]   frame_width,
  input  logic [c3f_pkg::FH_W-1:0]   frame_height,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_blue,
  input  logic [7:0]                 in_green,
  input  logic [7:0]                 in_red,
  input  logic                       q_full,
  output logic                       q_push,
  output c3f_pkg::job_t              q_job
);
  import c3f_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > FW_W) ? CW : FW_W;

  typedef enum logic [1:0] {F_CLEAR, F_TAKE, F_WRITE} state_t;

  state_t            state;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     col_cnt;
  logic [ROW_W-1:0]  row_cnt;
  logic [AW-1:0]     col_q;
  logic [ROW_W-1:0]  row_q;
  pixel_t            px_q;
  logic              interior_q;
  logic              border_q;
  pixel_t            win [6];

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [2*PIX_W-1:0] mem_wdata;

  logic [EW-1:0]     w_eff;
  logic [FH_W-1:0]   h_eff;
  logic [AW-1:0]     col_sel;
  logic [FH_W-1:0]   row_inc;
  logic [ROW_W-1:0]  row_now;
  logic [FH_W-1:0]   row_next;
  logic [EW-1:0]     col_plus;
  logic              interior;
  logic              border;
  logic              accept;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = EW'(1);
    end else if (EW'(frame_width) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = FH_W'(1);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    if (EW'(col_cnt) >= w_eff) begin
      col_sel = '0;
      row_inc = {1'b0, row_cnt} + FH_W'(1);
    end else begin
      col_sel = col_cnt;
      row_inc = {1'b0, row_cnt};
    end
    row_now  = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    row_next = {1'b0, row_now} + FH_W'(1);
    col_plus = EW'(col_sel) + EW'(1);
    interior = (row_now >= ROW_W'(2)) && (EW'(col_sel) >= EW'(2));
    border   = (row_now == '0) || ({1'b0, row_now} == h_eff - FH_W'(1)) ||
               (col_sel == '0) || (EW'(col_sel) == w_eff - EW'(1));
  end

  assign in_ready  = (state == F_TAKE) && !q_full;
  assign accept    = in_valid && in_ready;
  assign mem_we    = (state == F_CLEAR) || (state == F_WRITE);
  assign mem_addr  = (state == F_CLEAR) ? clr_addr : col_q;
  assign mem_wdata = (state == F_CLEAR) ? '0 : {rd_data[PIX_W-1:0], px_q};
  assign q_push    = (state == F_WRITE) && (interior_q || border_q);

  always_comb begin
    q_job.row      = row_q;
    q_job.col      = COL_W'(col_q);
    q_job.px       = px_q;
    q_job.interior = interior_q;
    q_job.border   = border_q;
    q_job.nb[0]    = win[0];
    q_job.nb[1]    = win[3];
    q_job.nb[2]    = rd_data[2*PIX_W-1:PIX_W];
    q_job.nb[3]    = win[1];
    q_job.nb[4]    = win[4];
    q_job.nb[5]    = rd_data[PIX_W-1:0];
    q_job.nb[6]    = win[2];
    q_job.nb[7]    = win[5];
    q_job.nb[8]    = px_q;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_addr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= line_mem[col_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_CLEAR;
      clr_addr <= '0;
      col_cnt  <= '0;
      row_cnt  <= '0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else begin
      unique case (state)
        F_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_WIDTH - 1)) begin
            state <= F_TAKE;
          end
        end
        F_TAKE: begin
          if (accept) begin
            px_q       <= {in_red, in_green, in_blue};
            col_q      <= col_sel;
            row_q      <= row_now;
            interior_q <= interior;
            border_q   <= border;
            if (col_plus >= w_eff) begin
              col_cnt <= '0;
              row_cnt <= (row_next >= h_eff) ? '0 : row_next[ROW_W-1:0];
            end else begin
              col_cnt <= col_plus[AW-1:0];
              row_cnt <= row_now;
            end
            state <= F_WRITE;
          end
        end
        F_WRITE: begin
          win[0] <= win[3];
          win[1] <= win[4];
          win[2] <= win[5];
          win[3] <= rd_data[2*PIX_W-1:PIX_W];
          win[4] <= rd_data[PIX_W-1:0];
          win[5] <= px_q;
          state  <= F_TAKE;
        end
        default: state <= F_CLEAR;
      endcase
    end
  end

endmodule

>>> src/c3f_queue.sv
// Two-entry job queue between the front and back ends of the filter.
// Depends on c3f_pkg for the job type.
module c3f_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  c3f_pkg::job_t push_job,
  input  logic          pop,
  output c3f_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import c3f_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = slots[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/c3f_back.sv
// Back end of the filter: weighted sum, divide, clamp and result output.
// One multiply-accumulate per tap, then a restoring divide. Depends on c3f_pkg.
module c3f_back #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  c3f_pkg::kernel_cfg_t         kcfg,
  input  logic                         q_empty,
  input  c3f_pkg::job_t                q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [c3f_pkg::ROW_W-1:0]    out_row,
  output logic [c3f_pkg::COL_W-1:0]    out_col,
  output logic [7:0]                   out_blue,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_red,
  output logic                         last_of_run
);
  import c3f_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE, B_MAC, B_PREP, B_DIV, B_FIN, B_OUT_I, B_OUT_B
  } state_t;

  state_t                 state;
  job_t                   job;
  logic [3:0]             tap;
  logic [1:0]             ky;
  logic [1:0]             kx;
  logic [2:0]             step;
  logic signed [ACC_W-1:0] acc [3];
  logic [23:0]            rem [3];
  logic [7:0]             quo [3];
  logic                   neg [3];
  logic                   sat [3];
  logic [22:0]            dsh;

  logic [KROW_W-1:0]      sel_row;
  logic [15:0]            slot;
  logic signed [15:0]     wt;
  pixel_t                 tap_px;
  logic signed [24:0]     prod [3];
  logic [DIV_W-1:0]       divisor;
  logic                   ge [3];
  logic [7:0]             res [3];

  always_comb begin
    case (ky)
      2'd0:    sel_row = kcfg.top;
      2'd1:    sel_row = kcfg.mid;
      default: sel_row = kcfg.bot;
    endcase
    case (kx)
      2'd0:    slot = sel_row[15:0];
      2'd1:    slot = sel_row[31:16];
      default: slot = sel_row[47:32];
    endcase
    wt      = 16'($signed(slot[WEIGHT_BITS-1:0]));
    tap_px  = job.nb[tap];
    divisor = (kcfg.divisor == '0) ? DIV_W'(1) : kcfg.divisor;
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = $signed({1'b0, tap_px[8*ch +: 8]}) * wt;
      ge[ch]   = rem[ch] >= {1'b0, dsh};
      res[ch]  = neg[ch] ? 8'd0 : (sat[ch] ? 8'(CH_MAX) : quo[ch]);
    end
  end

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            job <= q_head;
            if (q_head.interior) begin
              tap <= '0;
              ky  <= '0;
              kx  <= '0;
              for (int ch = 0; ch < 3; ch++) begin
                acc[ch] <= '0;
              end
              state <= B_MAC;
            end else begin
              out_row     <= q_head.row;
              out_col     <= q_head.col;
              out_blue    <= q_head.px[7:0];
              out_green   <= q_head.px[15:8];
              out_red     <= q_head.px[23:16];
              last_of_run <= 1'b1;
              out_valid   <= 1'b1;
              state       <= B_OUT_B;
            end
          end
        end
        B_MAC: begin
          for (int ch = 0; ch < 3; ch++) begin
            acc[ch] <= acc[ch] + ACC_W'(prod[ch]);
          end
          tap <= tap + 4'd1;
          if (kx == 2'(TAPS - 1)) begin
            kx <= '0;
            ky <= ky + 2'd1;
          end else begin
            kx <= kx + 2'd1;
          end
          if (tap == 4'd8) begin
            state <= B_PREP;
          end
        end
        B_PREP: begin
          for (int ch = 0; ch < 3; ch++) begin
            neg[ch] <= acc[ch] < 0;
            sat[ch] <= acc[ch] >= $signed({5'd0, divisor, 8'd0});
            rem[ch] <= acc[ch][23:0];
            quo[ch] <= '0;
          end
          dsh   <= {divisor, 7'd0};
          step  <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          for (int ch = 0; ch < 3; ch++) begin
            if (ge[ch]) begin
              rem[ch] <= rem[ch] - {1'b0, dsh};
            end
            quo[ch] <= {quo[ch][6:0], ge[ch]};
          end
          dsh  <= dsh >> 1;
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= B_FIN;
          end
        end
        B_FIN: begin
          out_row     <= job.row - ROW_W'(1);
          out_col     <= job.col - COL_W'(1);
          out_blue    <= res[0];
          out_green   <= res[1];
          out_red     <= res[2];
          last_of_run <= !job.border;
          out_valid   <= 1'b1;
          state       <= B_OUT_I;
        end
        B_OUT_I: begin
          if (out_ready) begin
            if (job.border) begin
              out_row     <= job.row;
              out_col     <= job.col;
              out_blue    <= job.px[7:0];
              out_green   <= job.px[15:8];
              out_red     <= job.px[23:16];
              last_of_run <= 1'b1;
              state       <= B_OUT_B;
            end else begin
              out_valid <= 1'b0;
              state     <= B_IDLE;
            end
          end
        end
        B_OUT_B: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> src/conv3x3_rgb_filter.sv
// Top level of the 3x3 RGB convolution filter: configuration registers and wiring.
// Depends on c3f_pkg, c3f_front, c3f_queue and c3f_back.

// The filter takes one blue/green/red pixel per input transfer in raster order and
// emits border pixels unchanged and interior pixels filtered, each with its row and
// column. The front end alternates between taking a pixel and writing back the
// line store memory, so it takes no new pixel before the last one is written back.
// A border-only pixel holds the back end until its result is taken. An interior
// pixel holds it while it takes the job, runs 9 multiply-accumulate steps, a setup
// step and 8 divide steps, loads the result and makes one result transfer, or two
// when it is also a border pixel. This sets the sustained rate on interior pixels,
// and output stalls lower it. A two-entry queue lets the front run ahead. After
// reset the line stores are cleared while in_ready stays low.
module conv3x3_rgb_filter #(
  parameter int MAX_WIDTH   = 2048,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [c3f_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c3f_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_blue,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_red,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [c3f_pkg::ROW_W-1:0]         out_row,
  output logic [c3f_pkg::COL_W-1:0]         out_col,
  output logic [7:0]                        out_blue,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_red,
  output logic                              last_of_run
);
  import c3f_pkg::*;

  kernel_cfg_t       kcfg;
  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  job_t              q_job;
  job_t              q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      kcfg.top     <= '0;
      kcfg.mid     <= KROW_W'(65536);
      kcfg.bot     <= '0;
      kcfg.divisor <= DIV_W'(1);
      frame_width  <= FW_W'(2048);
      frame_height <= FH_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL_TOP:    kcfg.top     <= cfg_data;
        REG_KERNEL_MIDDLE: kcfg.mid     <= cfg_data;
        REG_KERNEL_BOTTOM: kcfg.bot     <= cfg_data;
        REG_DIVIDE_BY:     kcfg.divisor <= cfg_data[DIV_W-1:0];
        REG_FRAME_WIDTH:   frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT:  frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  c3f_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_blue      (in_blue),
    .in_green     (in_green),
    .in_red       (in_red),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  c3f_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  c3f_back #(.WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .kcfg        (kcfg),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_blue    (out_blue),
    .out_green   (out_green),
    .out_red     (out_red),
    .last_of_run (last_of_run)
  );

endmodule

>>> src/c3f_checker.sv
// Port-level checks for the 3x3 RGB convolution filter, bound to the top level.
// Depends only on the top level's ports.
module c3f_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_row,
  input logic [10:0] out_col,
  input logic        last_of_run
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input accepted during line store clearing");

  a_no_output_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result presented right after reset");

  a_input_spacing: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input transfers in consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(last_of_run))
    else $error("stalled result changed");

endmodule

bind conv3x3_rgb_filter c3f_checker u_c3f_checker (.*);

>>> dv/tb.sv
// Self-checking testbench for the 3x3 RGB convolution filter conv3x3_rgb_filter.
// Depends on c3f_pkg and the filter RTL; predicts every result and compares in order.
module tb;
  import c3f_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd6;
  localparam int LINE_DEPTH = 2048;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic last;
  } pix_result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] in_blue = 0, in_green = 0, in_red = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [7:0] out_blue, out_green, out_red;
  logic last_of_run;

  conv3x3_rgb_filter dut (.*);

  always #1 clk = ~clk;

  // Predictor state.
  logic [KROW_W-1:0] kern [3];
  int unsigned divisor_cfg, width_cfg, height_cfg;
  pixel_t line_prev [LINE_DEPTH];
  pixel_t line_old [LINE_DEPTH];
  pixel_t window [6];
  int unsigned col_cnt, row_cnt;

  pix_result_t pending_pixels [$];
  int errors = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int filtered_seen = 0;
  bit quiet = 0;
  int hold_off = 0;

  function automatic longint weight_of(int ky, int kx);
    logic [KROW_W-1:0] r;
    r = kern[ky];
    return longint'($signed(r[16*kx +: 16]));
  endfunction

  function automatic void push_result(int unsigned row, int unsigned col, pixel_t px);
    pix_result_t e;
    e.row = row[ROW_W-1:0];
    e.col = col[COL_W-1:0];
    e.blue = px[7:0];
    e.green = px[15:8];
    e.red = px[23:16];
    e.last = 1'b0;
    pending_pixels.push_back(e);
  endfunction

  function automatic void predict_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int unsigned w, h, col, row, n;
    pixel_t px, c0, c1, res;
    pixel_t nb [3][3];
    longint s, q, dv;
    w = width_cfg;
    h = height_cfg;
    n = 0;
    if (w < 1) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    px = {r, g, b};
    c0 = line_old[col];
    c1 = line_prev[col];
    if (row >= 2 && col >= 2) begin
      dv = (divisor_cfg == 0) ? 1 : longint'(divisor_cfg);
      for (int ky = 0; ky < 3; ky++) begin
        nb[ky][0] = window[ky];
        nb[ky][1] = window[3+ky];
      end
      nb[0][2] = c0;
      nb[1][2] = c1;
      nb[2][2] = px;
      for (int ch = 0; ch < 3; ch++) begin
        s = 0;
        for (int ky = 0; ky < 3; ky++)
          for (int kx = 0; kx < 3; kx++)
            s += longint'(nb[ky][kx][8*ch +: 8]) * weight_of(ky, kx);
        q = s / dv;
        if (q < 0) q = 0;
        if (q > CH_MAX) q = CH_MAX;
        res[8*ch +: 8] = q[7:0];
      end
      push_result(row - 1, col - 1, res);
      n++;
    end
    if (row == 0 || row == h - 1 || col == 0 || col == w - 1) begin
      push_result(row, col, px);
      n++;
    end
    if (n > 0) pending_pixels[pending_pixels.size()-1].last = 1;
    line_old[col] = c1;
    line_prev[col] = px;
    window[0] = window[3];
    window[1] = window[4];
    window[2] = window[5];
    window[3] = c0;
    window[4] = c1;
    window[5] = px;
    col_cnt = col + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endfunction

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 5)) @(negedge clk);
  endtask

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    idle_burst();
    in_valid = 1;
    in_blue = b;
    in_green = g;
    in_red = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(b, g, r);
    pixels_sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      REG_KERNEL_TOP: kern[0] = value;
      REG_KERNEL_MIDDLE: kern[1] = value;
      REG_KERNEL_BOTTOM: kern[2] = value;
      REG_DIVIDE_BY: divisor_cfg = 32'(value[15:0]);
      REG_FRAME_WIDTH: width_cfg = 32'(value[11:0]);
      REG_FRAME_HEIGHT: height_cfg = 32'(value[12:0]);
      default: ;
    endcase
  endtask

  function automatic logic [KROW_W-1:0] pack_row(int l, int c, int r);
    logic [15:0] a, m, z;
    a = l[15:0];
    m = c[15:0];
    z = r[15:0];
    return {z, m, a};
  endfunction

  task automatic set_frame(int w, int h);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
  endtask

  task automatic test_identity();
    set_frame(4, 4);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h55, 8'haa, 8'h0f);
    send_pixel(8'hf0, 8'h01, 8'h80);
    repeat (12) send_random_pixel();
  endtask

  task automatic test_extreme_kernels();
    write_reg(REG_KERNEL_TOP, pack_row(32767, -32768, 32767));
    write_reg(REG_KERNEL_MIDDLE, pack_row(-32768, 32767, -32768));
    write_reg(REG_KERNEL_BOTTOM, pack_row(1, 1, 1));
    write_reg(REG_DIVIDE_BY, CFG_DATA_W'(65535));
    repeat (9) send_pixel(8'hff, 8'hff, 8'hff);
    write_reg(REG_DIVIDE_BY, '0);
    write_reg(REG_KERNEL_TOP, pack_row(-1, -1, -1));
    write_reg(CFG_UNUSED_INDEX, '1);
    repeat (16) send_random_pixel();
  endtask

  task automatic test_frame_sizes();
    set_frame(1, 5);
    repeat (6) send_random_pixel();
    set_frame(2, 1);
    repeat (5) send_random_pixel();
    set_frame(0, 0);
    repeat (3) send_random_pixel();
    set_frame(3, 4096);
    repeat (12) send_random_pixel();
    set_frame(700, 3);
    repeat (700 + 5) send_random_pixel();
    set_frame(4095, 8191);
    repeat (4) send_random_pixel();
  endtask

  task automatic test_backpressure();
    write_reg(REG_KERNEL_TOP, pack_row(1, 2, 1));
    write_reg(REG_KERNEL_MIDDLE, pack_row(2, 4, 2));
    write_reg(REG_KERNEL_BOTTOM, pack_row(1, 2, 1));
    write_reg(REG_DIVIDE_BY, CFG_DATA_W'(16));
    set_frame(5, 5);
    hold_off = 400;
    repeat (40) send_random_pixel();
  endtask

  task automatic random_phase();
    int w, h, n;
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 3; i++)
        write_reg(CFG_IDX_W'(REG_KERNEL_TOP + i), CFG_DATA_W'({$urandom, $urandom}));
      write_reg(REG_DIVIDE_BY, CFG_DATA_W'($urandom_range(1, 65535)));
    end else begin
      for (int i = 0; i < 3; i++)
        write_reg(CFG_IDX_W'(REG_KERNEL_TOP + i), pack_row($urandom_range(0, 8) - 4,
                  $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4));
      write_reg(REG_DIVIDE_BY, CFG_DATA_W'($urandom_range(1, 8)));
    end
    w = $urandom_range(0, 4) == 0 ? $urandom_range(1, 16) : $urandom_range(3, 7);
    h = $urandom_range(0, 4) == 0 ? $urandom_range(1, 10) : $urandom_range(3, 6);
    set_frame(w, h);
    n = w * h * $urandom_range(1, 3) + ($urandom_range(0, 2) == 0 ? $urandom_range(1, w) : 0);
    repeat (n) send_random_pixel();
  endtask

  task automatic test_random();
    while (pixels_sent < 1650) begin
      if (pixels_sent > 1450) quiet = 1;
      random_phase();
    end
  endtask

  // Receiver side: random stalls plus one long hold-off.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ready = 0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        out_ready = 1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pix_result_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d", $time, out_row, out_col);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (!(e.row == out_row && e.col == out_col && e.blue == out_blue &&
              e.green == out_green && e.red == out_red && e.last == last_of_run)) begin
          $display("%0t: mismatch expected r%0d c%0d b%0d g%0d r%0d l%0d", $time,
                   e.row, e.col, e.blue, e.green, e.red, e.last);
          $display("%0t:          actual   r%0d c%0d b%0d g%0d r%0d l%0d", $time,
                   out_row, out_col, out_blue, out_green, out_red, last_of_run);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    kern[0] = '0;
    kern[1] = 48'h10000;
    kern[2] = '0;
    divisor_cfg = 1;
    width_cfg = 2048;
    height_cfg = 1024;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_prev[i] = '0;
      line_old[i] = '0;
    end
    for (int i = 0; i < 6; i++) window[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    repeat (10) @(negedge clk);
    rst = 0;
    test_identity();
    test_extreme_kernels();
    test_frame_sizes();
    test_backpressure();
    test_random();
    drain();
    if (pending_pixels.size() != 0) errors++;
    $display("Sent %0d pixels over many kernel and frame settings; checked %0d results.",
             pixels_sent, results_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/c3f_pkg.sv
src/c3f_front.sv
src/c3f_queue.sv
src/c3f_back.sv
src/conv3x3_rgb_filter.sv
src/c3f_checker.sv
dv/tb.sv
